@@ src/assert_macros.svh @@
// Assertion macros used by the column build sequencer (spbwt_ctrl).
// Empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ src/spbwt_pkg.sv @@
// Shared widths and controller/datapath interface structs of the column build.
// No dependencies.
`default_nettype none
package spbwt_pkg;
	localparam int HAP_W = 6;
	localparam int CNT_W = 7;
	localparam int DIV_W = 16;
	localparam int DEF_MAX_HAPLOTYPES = 64;
	localparam int DEF_SYLLABLE_BITS = 64;
	localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;
	localparam logic [DIV_W-1:0] COL_MAX = 16'hFFFF;

	typedef struct packed {
		logic load;
		logic i_clr;
		logic i_inc;
		logic rd_ord;
		logic rd_syl;
		logic gat_wr;
		logic rd_i;
		logic rd_j;
		logic cmp;
		logic rank_wr;
		logic r_clr;
		logic rd_r;
		logic div_eval;
		logic rd_pd;
		logic acc;
		logic j_inc;
		logic out_ld;
		logic r_inc;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic last_i;
		logic last_j;
		logic tie;
		logic range_end;
		logic last_r;
	} sts_t;
endpackage
`default_nettype wire

@@ src/spbwt_dp.sv @@
// Datapath: syllable store, gather/rank/divergence buffers, banked order and
// divergence stores, counters and output register. Uses spbwt_pkg.
`default_nettype none
module spbwt_dp import spbwt_pkg::*; #(
	parameter int MAX_HAPLOTYPES = DEF_MAX_HAPLOTYPES,
	parameter int SYLLABLE_BITS = DEF_SYLLABLE_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic              restart,
	input  wire logic [CNT_W-1:0]  cfg_count,
	input  wire logic [HAP_W-1:0]  haplotype,
	input  wire logic [63:0]       syllable,
	output logic [HAP_W-1:0]       rank,
	output logic [HAP_W-1:0]       sorted_haplotype,
	output logic [DIV_W-1:0]       divergence,
	output logic                   final_rank
);
	localparam int IW = $clog2(MAX_HAPLOTYPES);
	localparam int CW = IW + 1;
	localparam int SB = SYLLABLE_BITS;

	logic [SB-1:0] syl_mem  [MAX_HAPLOTYPES];
	logic [SB-1:0] sp_mem   [MAX_HAPLOTYPES];
	logic [IW-1:0] op_mem   [MAX_HAPLOTYPES];
	logic [IW-1:0] nord_mem [MAX_HAPLOTYPES];
	logic [IW-1:0] fpos_mem [MAX_HAPLOTYPES];
	logic [SB-1:0] nsyl_mem [MAX_HAPLOTYPES];
	logic [IW-1:0] ord_mem  [2*MAX_HAPLOTYPES];
	logic [DIV_W-1:0] div_mem [2*MAX_HAPLOTYPES];

	logic [IW-1:0] i_q, j_q, r_q, cnt_q, pfpos_q;
	logic [IW-1:0] ord_rd_q, opa_q, nord_rd_q, fpos_rd_q;
	logic [SB-1:0] syl_rd_q, spa_q, spb_q, nsyl_rd_q, psyl_q;
	logic [DIV_W-1:0] pd_rd_q, best_q, column_q;
	logic bank_q, fresh_q, tie_q;

	logic [CW-1:0] m;
	logic [IW-1:0] mm1;
	logic [DIV_W-1:0] count, div_val;
	logic hap_ok, less;

	always_comb begin
		if (cfg_count == '0) begin
			m = CW'(1);
		end else if (cfg_count > CNT_W'(MAX_HAPLOTYPES)) begin
			m = CW'(MAX_HAPLOTYPES);
		end else begin
			m = cfg_count[CW-1:0];
		end
	end
	assign mm1 = IW'(m - CW'(1));
	assign hap_ok = {1'b0, haplotype} < CNT_W'(m);
	assign count = (column_q == COL_MAX) ? COL_MAX : column_q + DIV_W'(1);
	assign less = (spb_q < spa_q) || ((spb_q == spa_q) && (j_q < i_q));
	assign div_val = tie_q ? best_q : count;

	assign sts.last_i = (i_q == mm1);
	assign sts.last_j = (j_q == mm1);
	assign sts.tie = (r_q != '0) && (nsyl_rd_q == psyl_q);
	assign sts.range_end = (j_q == fpos_rd_q);
	assign sts.last_r = (r_q == mm1);

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load && hap_ok) syl_mem[haplotype[IW-1:0]] <= syllable[SB-1:0];
		if (cmd.rd_syl) syl_rd_q <= syl_mem[ord_rd_q];
		if (cmd.gat_wr) begin
			sp_mem[i_q] <= syl_rd_q;
			op_mem[i_q] <= ord_rd_q;
		end
		if (cmd.rd_i) begin
			spa_q <= sp_mem[i_q];
			opa_q <= op_mem[i_q];
		end
		if (cmd.rd_j) spb_q <= sp_mem[j_q];
		if (cmd.rank_wr) begin
			nord_mem[cnt_q] <= opa_q;
			fpos_mem[cnt_q] <= i_q;
			nsyl_mem[cnt_q] <= spa_q;
		end
		if (cmd.rd_r) begin
			nord_rd_q <= nord_mem[r_q];
			fpos_rd_q <= fpos_mem[r_q];
			nsyl_rd_q <= nsyl_mem[r_q];
		end
		// before the first column the stores read as identity order and zero
		if (cmd.rd_ord) ord_rd_q <= fresh_q ? i_q : ord_mem[{bank_q, i_q}];
		if (cmd.rd_pd) pd_rd_q <= fresh_q ? '0 : div_mem[{bank_q, j_q}];
		if (cmd.out_ld) begin
			ord_mem[{~bank_q, r_q}] <= nord_rd_q;
			div_mem[{~bank_q, r_q}] <= div_val;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.div_eval) begin
			tie_q <= sts.tie;
			j_q <= pfpos_q + IW'(1);
			best_q <= '0;
		end else if (cmd.rd_i) begin
			j_q <= '0;
		end else if (cmd.cmp || cmd.j_inc) begin
			j_q <= j_q + IW'(1);
		end
		if (cmd.acc && pd_rd_q > best_q) best_q <= pd_rd_q;
		if (cmd.rd_i) cnt_q <= '0;
		else if (cmd.cmp && less) cnt_q <= cnt_q + IW'(1);
		if (cmd.out_ld) begin
			pfpos_q <= fpos_rd_q;
			psyl_q <= nsyl_rd_q;
			rank <= HAP_W'(r_q);
			sorted_haplotype <= HAP_W'(nord_rd_q);
			divergence <= div_val;
			final_rank <= sts.last_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			r_q <= '0;
			bank_q <= 1'b0;
			fresh_q <= 1'b1;
			column_q <= '0;
		end else begin
			if (cmd.i_clr) i_q <= '0;
			else if (cmd.i_inc) i_q <= i_q + IW'(1);
			if (cmd.r_clr) r_q <= '0;
			else if (cmd.r_inc) r_q <= r_q + IW'(1);
			if (restart) begin
				fresh_q <= 1'b1;
				column_q <= '0;
			end else if (cmd.commit) begin
				bank_q <= ~bank_q;
				fresh_q <= 1'b0;
				column_q <= count;
			end
		end
	end
endmodule
`default_nettype wire

@@ src/spbwt_ctrl.sv @@
// Sequencer for load, gather, rank, divergence and emit phases.
// Uses spbwt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module spbwt_ctrl import spbwt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic column_done,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_G0   = 14'b00000000000010,
		S_G1   = 14'b00000000000100,
		S_G2   = 14'b00000000001000,
		S_R0   = 14'b00000000010000,
		S_R2   = 14'b00000000100000,
		S_R3   = 14'b00000001000000,
		S_R4   = 14'b00000010000000,
		S_D0   = 14'b00000100000000,
		S_D1   = 14'b00001000000000,
		S_D2   = 14'b00010000000000,
		S_D3   = 14'b00100000000000,
		S_EM   = 14'b01000000000000,
		S_WT   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_WT);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (column_done) begin
						cmd.i_clr = 1'b1;
						state_d = S_G0;
					end
				end
			end
			S_G0: begin
				cmd.rd_ord = 1'b1;
				state_d = S_G1;
			end
			S_G1: begin
				cmd.rd_syl = 1'b1;
				state_d = S_G2;
			end
			S_G2: begin
				cmd.gat_wr = 1'b1;
				if (sts.last_i) begin
					cmd.i_clr = 1'b1;
					state_d = S_R0;
				end else begin
					cmd.i_inc = 1'b1;
					state_d = S_G0;
				end
			end
			S_R0: begin
				cmd.rd_i = 1'b1;
				state_d = S_R2;
			end
			S_R2: begin
				cmd.rd_j = 1'b1;
				state_d = S_R3;
			end
			S_R3: begin
				cmd.cmp = 1'b1;
				state_d = sts.last_j ? S_R4 : S_R2;
			end
			S_R4: begin
				cmd.rank_wr = 1'b1;
				if (sts.last_i) begin
					cmd.r_clr = 1'b1;
					state_d = S_D0;
				end else begin
					cmd.i_inc = 1'b1;
					state_d = S_R0;
				end
			end
			S_D0: begin
				cmd.rd_r = 1'b1;
				state_d = S_D1;
			end
			S_D1: begin
				cmd.div_eval = 1'b1;
				state_d = sts.tie ? S_D2 : S_EM;
			end
			S_D2: begin
				cmd.rd_pd = 1'b1;
				state_d = S_D3;
			end
			S_D3: begin
				cmd.acc = 1'b1;
				if (sts.range_end) begin
					state_d = S_EM;
				end else begin
					cmd.j_inc = 1'b1;
					state_d = S_D2;
				end
			end
			S_EM: begin
				cmd.out_ld = 1'b1;
				state_d = S_WT;
			end
			S_WT: begin
				if (out_ready) begin
					if (sts.last_r) begin
						cmd.commit = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.r_inc = 1'b1;
						state_d = S_D0;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`ASSERT_NXT(a_build_starts, clk, arst_n, in_valid && in_ready && column_done, !in_ready)
	`ASSERT_NXT(a_commit_idle, clk, arst_n, out_valid && out_ready && sts.last_r, in_ready)
	`ASSERT_NXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

@@ src/syllable_pbwt_column_build_core.sv @@
// Column build of a syllable-based positional BWT: one item per cycle while loading;
// the item with column_done starts a build over m haplotypes (rank pass with one
// comparator), m = count clamped to 1..MAX_HAPLOTYPES.
// Results leave one at a time from the output register.
// Reset (arst_n, async, active low) sets count 64, identity order, zero divergences.
`default_nettype none
module syllable_pbwt_column_build_core import spbwt_pkg::*; #(
	parameter int MAX_HAPLOTYPES = DEF_MAX_HAPLOTYPES,
	parameter int SYLLABLE_BITS = DEF_SYLLABLE_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [HAP_W-1:0]  haplotype,
	input  wire logic [63:0]       syllable,
	input  wire logic              column_done,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [HAP_W-1:0]       rank,
	output logic [HAP_W-1:0]       sorted_haplotype,
	output logic [DIV_W-1:0]       divergence,
	output logic                   final_rank
);
	logic [CNT_W-1:0] count_q;
	logic cfg_wr;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
	assign prdata = (paddr == 3'd0) ? {25'd0, count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_RESET;
		end else if (cfg_wr) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	spbwt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .column_done, .in_ready,
		.out_valid, .out_ready, .sts, .cmd
	);

	spbwt_dp #(
		.MAX_HAPLOTYPES(MAX_HAPLOTYPES),
		.SYLLABLE_BITS(SYLLABLE_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .sts, .restart(cfg_wr), .cfg_count(count_q),
		.haplotype, .syllable, .rank, .sorted_haplotype, .divergence, .final_rank
	);
endmodule
`default_nettype wire
